// ----- hdl/spdq_pkg.sv -----
// shared types and constants of the sorted pair dispatch queue
package spdq_pkg;

  localparam int REQ_W    = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 5;
  localparam int COUNT_W  = 6;
  localparam int PAIR_SIZE = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD   = 2'd0,
    REQ_TAKE  = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_DUP    = 3'd2,
    ST_FEW    = 3'd3,
    ST_BADIDX = 3'd4,
    ST_NULL   = 3'd5
  } status_t;

endpackage

// ----- hdl/spdq_ram.sv -----
// generic single write port ram with registered read
module spdq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/sorted_pair_dispatch_queue_unit.sv -----
// top level: sorted (id, score) queue with add, take pair, peek and clear requests
//
// Keeps up to QUEUE_DEPTH entries in one ram, packed from slot 0 and sorted by
// descending score, earlier arrivals first among equal scores. One small
// sequencer walks the ram through its single read and single write port, one
// visited slot at a time. An add scans the queued entries for a duplicate id
// and the insert point, moves each entry at and behind that point down one
// slot, tail first, and writes the new entry; an add whose id is already
// queued stops the scan at that slot. A take pair reads every slot, and a peek
// reads one; a clear and a null id or full queue add do no ram work. Every
// item ends by loading the result register. in_ready is high only while the
// sequencer is idle. A finished result waits in the output register, so the
// next item may start while the previous result is still being taken; that
// item cannot finish until the output register is free again. Every item
// gives exactly one result; entry_count is the queue size after the request.
module sorted_pair_dispatch_queue_unit #(
  parameter int QUEUE_DEPTH = 32,
  parameter int ID_BITS     = 16,
  parameter int SCORE_BITS  = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [spdq_pkg::REQ_W-1:0]    in_req_type,
  input  logic [ID_BITS-1:0]            in_player_id,
  input  logic [SCORE_BITS-1:0]         in_score,
  input  logic [spdq_pkg::SLOT_W-1:0]   in_slot_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spdq_pkg::STATUS_W-1:0] out_status,
  output logic [ID_BITS-1:0]            out_first_id,
  output logic [SCORE_BITS-1:0]         out_first_score,
  output logic [ID_BITS-1:0]            out_second_id,
  output logic [spdq_pkg::COUNT_W-1:0]  out_entry_count
);

  import spdq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int WW = ID_BITS + SCORE_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_TAKE_RD,
    S_TAKE_MV,
    S_PEEK_RD,
    S_PEEK_CAP,
    S_FINISH
  } state_t;

  state_t                state_r;
  logic [CW-1:0]         count_r;     // queued entries
  logic [CW-1:0]         idx_r;       // slot walked by the sequencer
  logic [CW-1:0]         pos_r;       // insert point of an add
  logic                  found_r;     // insert point already seen in scan
  logic [ID_BITS-1:0]    req_id_r;
  logic [SCORE_BITS-1:0] req_sc_r;

  // result being built, moved to the output register at finish
  status_t               res_status_r;
  logic [ID_BITS-1:0]    res_fid_r;
  logic [SCORE_BITS-1:0] res_fsc_r;
  logic [ID_BITS-1:0]    res_sid_r;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [ID_BITS-1:0]    out_fid_r;
  logic [SCORE_BITS-1:0] out_fsc_r;
  logic [ID_BITS-1:0]    out_sid_r;
  logic [COUNT_W-1:0]    out_count_r;

  // ram port
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [WW-1:0]         ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [WW-1:0]         ram_rdata;

  logic [CW-1:0]         idx_m1;
  logic [CW-1:0]         idx_m2;
  logic [CW-1:0]         count_m1;
  logic [ID_BITS-1:0]    rd_id;
  logic [SCORE_BITS-1:0] rd_sc;
  logic                  scan_last;
  logic                  score_lower;
  logic [CW-1:0]         pos_fin;

  spdq_ram #(
    .WIDTH (WW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign idx_m1      = idx_r - CW'(1);
  assign idx_m2      = idx_r - CW'(PAIR_SIZE);
  assign count_m1    = count_r - CW'(1);
  assign rd_id       = ram_rdata[WW-1:SCORE_BITS];
  assign rd_sc       = ram_rdata[SCORE_BITS-1:0];
  assign scan_last   = (idx_r == count_m1);
  assign score_lower = (rd_sc < req_sc_r);

  // first slot whose score is below the new one, else the tail
  always_comb begin
    if (found_r) begin
      pos_fin = pos_r;
    end else if (score_lower) begin
      pos_fin = idx_r;
    end else begin
      pos_fin = count_r;
    end
  end

  // ram addressing per sequencer step
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_r[AW-1:0];
    case (state_r)
      S_SHIFT_RD: begin
        ram_raddr = idx_m1[AW-1:0];
      end
      S_SHIFT_WR: begin
        ram_we = 1'b1;
      end
      S_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[AW-1:0];
        ram_wdata = {req_id_r, req_sc_r};
      end
      S_TAKE_MV: begin
        // entries behind the head pair move up two slots
        ram_we    = (idx_r >= CW'(PAIR_SIZE));
        ram_waddr = idx_m2[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // finish handles the output register itself
      if (out_valid_r && out_ready && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_id_r     <= in_player_id;
            req_sc_r     <= in_score;
            res_status_r <= ST_OK;
            res_fid_r    <= '0;
            res_fsc_r    <= '0;
            res_sid_r    <= '0;
            idx_r        <= '0;
            found_r      <= 1'b0;
            pos_r        <= '0;
            state_r      <= S_FINISH;
            case (req_t'(in_req_type))
              REQ_ADD: begin
                if (in_player_id == '0) begin
                  res_status_r <= ST_NULL;
                end else if (count_r == CW'(QUEUE_DEPTH)) begin
                  res_status_r <= ST_FULL;
                end else if (count_r == '0) begin
                  state_r <= S_INSERT;
                end else begin
                  state_r <= S_SCAN_RD;
                end
              end
              REQ_TAKE: begin
                if (count_r < CW'(PAIR_SIZE)) begin
                  res_status_r <= ST_FEW;
                end else begin
                  state_r <= S_TAKE_RD;
                end
              end
              REQ_PEEK: begin
                if (32'(in_slot_index) >= 32'(count_r)) begin
                  res_status_r <= ST_BADIDX;
                end else begin
                  idx_r   <= CW'(in_slot_index);
                  state_r <= S_PEEK_RD;
                end
              end
              default: begin
                count_r <= '0;
              end
            endcase
          end
        end

        // duplicate check and insert point search, one slot at a time
        S_SCAN_RD: begin
          state_r <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (rd_id == req_id_r) begin
            res_status_r <= ST_DUP;
            state_r      <= S_FINISH;
          end else if (scan_last) begin
            pos_r <= pos_fin;
            idx_r <= count_r;
            if (count_r > pos_fin) begin
              state_r <= S_SHIFT_RD;
            end else begin
              state_r <= S_INSERT;
            end
          end else begin
            pos_r   <= pos_fin;
            found_r <= found_r || score_lower;
            idx_r   <= idx_r + CW'(1);
            state_r <= S_SCAN_RD;
          end
        end

        // move entries at and behind the insert point down one slot, tail first
        S_SHIFT_RD: begin
          state_r <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          idx_r <= idx_m1;
          if (idx_m1 == pos_r) begin
            state_r <= S_INSERT;
          end else begin
            state_r <= S_SHIFT_RD;
          end
        end
        S_INSERT: begin
          count_r <= count_r + CW'(1);
          state_r <= S_FINISH;
        end

        // read every slot: capture the head pair, copy the rest up
        S_TAKE_RD: begin
          state_r <= S_TAKE_MV;
        end
        S_TAKE_MV: begin
          if (idx_r == '0) begin
            res_fid_r <= rd_id;
            res_fsc_r <= rd_sc;
          end
          if (idx_r == CW'(1)) begin
            res_sid_r <= rd_id;
          end
          if (scan_last) begin
            count_r <= count_r - CW'(PAIR_SIZE);
            state_r <= S_FINISH;
          end else begin
            idx_r   <= idx_r + CW'(1);
            state_r <= S_TAKE_RD;
          end
        end

        S_PEEK_RD: begin
          state_r <= S_PEEK_CAP;
        end
        S_PEEK_CAP: begin
          res_fid_r <= rd_id;
          res_fsc_r <= rd_sc;
          state_r   <= S_FINISH;
        end

        // hand the result over once the output register is free
        S_FINISH: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_fid_r    <= res_fid_r;
            out_fsc_r    <= res_fsc_r;
            out_sid_r    <= res_sid_r;
            out_count_r  <= COUNT_W'(count_r);
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_first_id    = out_fid_r;
  assign out_first_score = out_fsc_r;
  assign out_second_id   = out_sid_r;
  assign out_entry_count = out_count_r;

endmodule

// ----- hdl/spdq_checker.sv -----
// port level checker of the sorted pair dispatch queue, bound to the top level
module spdq_checker #(
  parameter int QUEUE_DEPTH = 32,
  parameter int ID_BITS     = 16,
  parameter int SCORE_BITS  = 24
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [spdq_pkg::REQ_W-1:0]    in_req_type,
  input logic [ID_BITS-1:0]            in_player_id,
  input logic [SCORE_BITS-1:0]         in_score,
  input logic [spdq_pkg::SLOT_W-1:0]   in_slot_index,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [spdq_pkg::STATUS_W-1:0] out_status,
  input logic [ID_BITS-1:0]            out_first_id,
  input logic [SCORE_BITS-1:0]         out_first_score,
  input logic [ID_BITS-1:0]            out_second_id,
  input logic [spdq_pkg::COUNT_W-1:0]  out_entry_count
);

  import spdq_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_first_id) && $stable(out_first_score) &&
      $stable(out_second_id) && $stable(out_entry_count))
    else $error("result changed while stalled");

  // ready drops after every accepted item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an accepted item");

  // rejected requests carry no entry
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_first_id == '0 && out_first_score == '0 && out_second_id == '0)
    else $error("rejected request returned an entry");

  // a second id only comes from a good take, with a real head entry
  a_pair_whole: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_second_id != '0 |-> out_first_id != '0 && out_status == ST_OK)
    else $error("second id without a head entry");

  // queue size never passes its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_entry_count) <= QUEUE_DEPTH)
    else $error("entry count above queue depth");

endmodule

bind sorted_pair_dispatch_queue_unit spdq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .ID_BITS     (ID_BITS),
  .SCORE_BITS  (SCORE_BITS)
) u_spdq_checker (.*);
